### src/lfd_pkg.sv
// Shared types and constants of the lidar frame decoder.
package lfd_pkg;

    // Frame layout
    localparam logic [7:0] START_BYTE    = 8'hFA;
    localparam int         POS_W         = 5;
    localparam logic [4:0] POS_HUNT      = 5'd0;
    localparam logic [4:0] POS_INDEX     = 5'd1;
    localparam logic [4:0] POS_SPEED_LO  = 5'd2;
    localparam logic [4:0] POS_SPEED_HI  = 5'd3;
    localparam logic [4:0] POS_RDG_FIRST = 5'd4;
    localparam logic [4:0] POS_RDG_LAST  = 5'd19;
    localparam logic [4:0] POS_CHK_LO    = 5'd20;
    localparam logic [4:0] POS_CHK_HI    = 5'd21;

    // Checksum: ten words, each step doubles, so 16 + 10 bits
    localparam int ACC_W = 26;
    localparam int CHK_W = 15;

    // Readings
    localparam int         NUM_RDG   = 4;
    localparam int         RDG_BITS  = 32;
    localparam int         SLOT_W    = 2;
    localparam logic [1:0] LAST_SLOT = 2'd3;

    // Configuration register indexes
    localparam int         CFG_IDX_W        = 2;
    localparam int         CFG_DATA_W       = 16;
    localparam logic [1:0] CFG_TARGET_SPEED = 2'd0;
    localparam logic [1:0] CFG_DUTY_MAX     = 2'd1;
    localparam logic [1:0] CFG_DUTY_MIN     = 2'd2;

    localparam logic [15:0] TARGET_SPEED_RST = 16'd19200;
    localparam logic [15:0] DUTY_MAX_RST     = 16'd10000;
    localparam logic [15:0] DUTY_MIN_RST     = 16'd1500;
    localparam logic [15:0] DUTY_RST         = 16'd1500;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]                  packet_index;
        logic [15:0]                 speed_raw;
        logic [NUM_RDG*RDG_BITS-1:0] readings;   // reading k at [32k +: 32]
    } t_frame;

endpackage

### src/lfd_byte_if.sv
// Byte channel carrying received serial bytes.
interface lfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### src/lfd_rdg_if.sv
// Reading channel carrying decoded lidar readings.
interface lfd_rdg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packet_index;
    logic [1:0]  reading_slot;
    logic [13:0] distance;
    logic        invalid_flag;
    logic        signal_alert;
    logic [15:0] signal_strength;
    logic [15:0] speed_raw;
    logic [15:0] pwm_duty;
    logic        last_reading;

    modport source (
        output valid, input ready,
        output packet_index, reading_slot, distance, invalid_flag,
        output signal_alert, signal_strength, speed_raw, pwm_duty, last_reading
    );
    modport sink (
        input valid, output ready,
        input packet_index, reading_slot, distance, invalid_flag,
        input signal_alert, signal_strength, speed_raw, pwm_duty, last_reading
    );
endinterface

### src/lfd_front.sv
// Front end: start hunt, frame capture and running checksum.
module lfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lfd_byte_if.sink          i_rx,
    input  logic              i_full,
    output logic              o_push,
    output lfd_pkg::t_frame   o_frame
);

    logic [lfd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [lfd_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [7:0]                r_lo, n_lo;
    logic                      r_lo_ok, n_lo_ok;
    logic [6:0]                r_chk_hi, n_chk_hi;
    logic [7:0]                r_index, n_index;
    logic [15:0]               r_speed, n_speed;
    logic [lfd_pkg::NUM_RDG*lfd_pkg::RDG_BITS-1:0] r_rd, n_rd;

    logic       accept;
    logic [7:0] b;
    logic [15:0] fold;

    // stall only the closing byte when the queue has no room
    assign i_rx.ready = (r_pos != lfd_pkg::POS_CHK_HI) || !i_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;

    // end-around fold of the accumulator to 15 bits
    assign fold = {1'b0, r_acc[lfd_pkg::CHK_W-1:0]}
                + {5'd0, r_acc[lfd_pkg::ACC_W-1:lfd_pkg::CHK_W]};

    always_comb begin
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_lo     = r_lo;
        n_lo_ok  = r_lo_ok;
        n_chk_hi = r_chk_hi;
        n_index  = r_index;
        n_speed  = r_speed;
        n_rd     = r_rd;
        o_push   = 1'b0;
        if (accept) begin
            if (r_pos == lfd_pkg::POS_HUNT) begin
                if (b == lfd_pkg::START_BYTE) begin
                    n_pos = lfd_pkg::POS_INDEX;
                    n_acc = '0;
                    n_lo  = b;
                end
            end else begin
                n_pos = r_pos + 5'd1;
                if (r_pos[0] && (r_pos <= lfd_pkg::POS_RDG_LAST)) begin
                    n_acc = {r_acc[lfd_pkg::ACC_W-2:0], 1'b0} + {10'd0, b, r_lo};
                end else begin
                    n_lo = b;
                end
                if (r_pos == lfd_pkg::POS_INDEX) begin
                    n_index = b;
                end
                if ((r_pos == lfd_pkg::POS_SPEED_LO) || (r_pos == lfd_pkg::POS_SPEED_HI)) begin
                    n_speed = {b, r_speed[15:8]};
                end
                if ((r_pos >= lfd_pkg::POS_RDG_FIRST) && (r_pos <= lfd_pkg::POS_RDG_LAST)) begin
                    n_rd = {b, r_rd[lfd_pkg::NUM_RDG*lfd_pkg::RDG_BITS-1:8]};
                end
                if (r_pos == lfd_pkg::POS_CHK_LO) begin
                    n_lo_ok  = (fold[7:0] == b);
                    n_chk_hi = fold[14:8];
                end
                if (r_pos == lfd_pkg::POS_CHK_HI) begin
                    n_pos  = lfd_pkg::POS_HUNT;
                    o_push = r_lo_ok && (b == {1'b0, r_chk_hi});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= lfd_pkg::POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_lo     <= n_lo;
        r_lo_ok  <= n_lo_ok;
        r_chk_hi <= n_chk_hi;
        r_index  <= n_index;
        r_speed  <= n_speed;
        r_rd     <= n_rd;
    end

    assign o_frame.packet_index = r_index;
    assign o_frame.speed_raw    = r_speed;
    assign o_frame.readings     = r_rd;

endmodule

### src/lfd_queue.sv
// Two-entry frame queue between front and back.
module lfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lfd_pkg::t_frame   i_frame,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output lfd_pkg::t_frame   o_frame
);

    lfd_pkg::t_frame r_mem [lfd_pkg::QUEUE_DEPTH];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'(lfd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_frame = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

endmodule

### src/lfd_back.sv
// Back end: duty step, config registers and reading beats.
module lfd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_empty,
    input  lfd_pkg::t_frame                 i_frame,
    output logic                            o_pop,
    lfd_rdg_if.source                       o_rd
);

    logic [15:0] r_target, r_max, r_min;
    logic [15:0] r_duty, n_duty;
    logic        r_busy;
    logic [lfd_pkg::SLOT_W-1:0] r_slot;
    lfd_pkg::t_frame            r_ent;

    logic        beat;
    logic [lfd_pkg::RDG_BITS-1:0] rd;

    assign beat  = o_rd.valid && o_rd.ready;
    assign o_pop = !i_empty && (!r_busy || (beat && (r_slot == lfd_pkg::LAST_SLOT)));

    // duty step from the incoming frame's speed
    always_comb begin
        n_duty = r_duty;
        if (i_frame.speed_raw < r_target) begin
            if (r_duty < r_max) begin
                n_duty = r_duty + 16'd1;
            end
        end else if (i_frame.speed_raw > r_target) begin
            if (r_duty > r_min) begin
                n_duty = r_duty - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= lfd_pkg::TARGET_SPEED_RST;
            r_max    <= lfd_pkg::DUTY_MAX_RST;
            r_min    <= lfd_pkg::DUTY_MIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfd_pkg::CFG_TARGET_SPEED: r_target <= i_cfg_data;
                lfd_pkg::CFG_DUTY_MAX:     r_max    <= i_cfg_data;
                lfd_pkg::CFG_DUTY_MIN:     r_min    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= lfd_pkg::DUTY_RST;
            r_busy <= 1'b0;
            r_slot <= '0;
        end else begin
            if (o_pop) begin
                r_duty <= n_duty;
                r_busy <= 1'b1;
                r_slot <= '0;
            end else if (beat) begin
                if (r_slot == lfd_pkg::LAST_SLOT) begin
                    r_busy <= 1'b0;
                end
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_frame;
        end
    end

    assign rd = r_ent.readings[{r_slot, 5'd0} +: lfd_pkg::RDG_BITS];

    assign o_rd.valid            = r_busy;
    assign o_rd.packet_index     = r_ent.packet_index;
    assign o_rd.reading_slot     = r_slot;
    assign o_rd.distance         = rd[13:0];
    assign o_rd.invalid_flag     = rd[15];
    assign o_rd.signal_alert     = rd[14];
    assign o_rd.signal_strength  = rd[31:16];
    assign o_rd.speed_raw        = r_ent.speed_raw;
    assign o_rd.pwm_duty         = r_duty;
    assign o_rd.last_reading     = (r_slot == lfd_pkg::LAST_SLOT);

endmodule

### src/lidar_frame_decoder_speed_loop_top.sv
// Top level of the lidar frame decoder with motor speed loop.
//
//  channel   dir  beat carries                                   handshake
//  --------  ---  ---------------------------------------------  ------------------
//  i_rx      in   rx_byte                                        valid/ready
//  o_rd      out  index, slot, distance, flags, strength,        valid/ready
//                 speed, pwm duty, last flag
//  i_cfg_*   in   register index and 16-bit value                write enable only
//
// Cycles: one byte beat per cycle. The front captures the frame and keeps the
//   checksum running as each word completes, so a 22-byte frame costs 22 beats; a
//   good frame yields four reading beats from the back, one per cycle while ready.
// Reset: synchronous, active low; front hunts for 0xFA, queue empties, duty 1500.
// Stalls: the two-entry frame queue decouples the sides; only the closing checksum
//   byte waits, and only while the queue is full.
module lidar_frame_decoder_speed_loop_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lfd_byte_if.sink                        i_rx,
    lfd_rdg_if.source                       o_rd,
    input  logic                            i_cfg_we,
    input  logic [lfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lfd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic            q_push, q_full, q_pop, q_empty;
    lfd_pkg::t_frame f_frame, q_frame;

    // front: hunt, capture, checksum
    lfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_frame (f_frame)
    );

    // good frames wait here for the back
    lfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (f_frame),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_frame (q_frame)
    );

    // back: duty loop and reading beats
    lfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (q_empty),
        .i_frame    (q_frame),
        .o_pop      (q_pop),
        .o_rd       (o_rd)
    );

    // a good frame is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("frame pushed into full queue");

    // duty moves at most one step per cycle
    a_duty_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (o_rd.pwm_duty == $past(o_rd.pwm_duty)) ||
            (o_rd.pwm_duty == $past(o_rd.pwm_duty) + 16'd1) ||
            (o_rd.pwm_duty == $past(o_rd.pwm_duty) - 16'd1))
        else $error("duty jumped by more than one");

    // readings of a frame follow one another without a gap in slot order
    a_slot_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rd.valid && o_rd.ready && !o_rd.last_reading) |=>
            (o_rd.valid && (o_rd.reading_slot == $past(o_rd.reading_slot) + 2'd1)))
        else $error("reading slot sequence broken");

endmodule
